// File: src/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg: shared types, tables and round functions
// This package holds the S-box tables, the AES round functions, the register
// codes and the command structs that join the controller and the datapaths.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

  localparam int MAX_ROUND_KEY_WORDS = 60;
  localparam int RK_ROWS = MAX_ROUND_KEY_WORDS / 4;
  localparam int RK_AW = $clog2(RK_ROWS);
  localparam int WIDX_W = $clog2(MAX_ROUND_KEY_WORDS);

  typedef enum logic [2:0] {
    CFG_KEY_SIZE = 3'd0,
    CFG_KEY_A    = 3'd1,
    CFG_KEY_B    = 3'd2,
    CFG_KEY_C    = 3'd3,
    CFG_KEY_D    = 3'd4,
    CFG_MODE     = 3'd5,
    CFG_IV_HIGH  = 3'd6,
    CFG_IV_LOW   = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_ECB = 2'd0,
    MODE_CBC = 2'd1,
    MODE_CFB = 2'd2,
    MODE_OFB = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KS_128 = 2'd0,
    KS_192 = 2'd1,
    KS_256 = 2'd2
  } key_size_t;

  typedef struct packed {
    logic              init;
    logic              step;
    logic [WIDX_W-1:0] widx;
    logic [2:0]        wmod;
  } kexp_cmd_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic round;
    logic last;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic core_dec_in;
  } dp_stat_t;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] ISBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sb(input logic [7:0] x);
    return SBOX_TBL[11'd2047 - {x, 3'b000} -: 8];
  endfunction

  function automatic logic [7:0] isb(input logic [7:0] x);
    return ISBOX_TBL[11'd2047 - {x, 3'b000} -: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sb(w[31:24]), sb(w[23:16]), sb(w[15:8]), sb(w[7:0])};
  endfunction

  function automatic logic [3:0] nr_of(input logic [1:0] ks);
    return (ks == KS_128) ? 4'd10 : ((ks == KS_192) ? 4'd12 : 4'd14);
  endfunction

  function automatic logic [3:0] nk_of(input logic [1:0] ks);
    return (ks == KS_128) ? 4'd4 : ((ks == KS_192) ? 4'd6 : 4'd8);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int i = 0; i < 4; i++) begin
      a[i]  = w[31-8*i -: 8];
      x2[i] = xt(a[i]);
      x4[i] = xt(x2[i]);
      x8[i] = xt(x4[i]);
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  // Byte k of a block sits at bits [127-8k -: 8]; column c is bytes 4c..4c+3.
  function automatic logic [127:0] enc_round(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic last);
    logic [127:0] t;
    logic [127:0] m;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = sb(s[127-8*(4*((c+r)%4)+r) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[127-32*c -: 32] = mix_col(t[127-32*c -: 32]);
    end
    return (last ? t : m) ^ rk;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic last);
    logic [127:0] t;
    logic [127:0] u;
    logic [127:0] m;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*((c+r)%4)+r) -: 8] = isb(s[127-8*(4*c+r) -: 8]);
      end
    end
    u = t ^ rk;
    for (int c = 0; c < 4; c++) begin
      m[127-32*c -: 32] = inv_mix_col(u[127-32*c -: 32]);
    end
    return last ? u : m;
  endfunction

endpackage
`default_nettype wire

// File: src/aes_ram.sv
// ----------------------------------------------------------------------------
// aes_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/aes_kexp.sv
// ----------------------------------------------------------------------------
// aes_kexp: key registers and key expansion datapath
// Produces one expanded key word per step and writes a round-key row to the
// store every fourth word.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_kexp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr,
  input  logic [2:0]               cfg_index,
  input  logic [63:0]              cfg_data,
  input  aes_pkg::kexp_cmd_t       cmd,
  output logic [1:0]               key_size,
  output logic                     rk_we,
  output logic [aes_pkg::RK_AW-1:0] rk_waddr,
  output logic [127:0]             rk_wdata
);

  localparam int WIDX_TOP = aes_pkg::WIDX_W - 1;

  logic [255:0] key;
  logic [31:0]  sh [8];
  logic [7:0]   rcon;
  logic [3:0]   nk;
  logic [31:0]  prev;
  logic [31:0]  back;
  logic [31:0]  word;
  logic         use_rcon;

  assign nk   = aes_pkg::nk_of(key_size);
  assign prev = sh[0];

  always_comb begin
    unique case (key_size)
      aes_pkg::KS_128: back = sh[3];
      aes_pkg::KS_192: back = sh[5];
      default:         back = sh[7];
    endcase
  end

  assign use_rcon = ({2'b00, cmd.widx} >= {4'd0, nk}) && (cmd.wmod == 3'd0);

  always_comb begin
    if ({2'b00, cmd.widx} < {4'd0, nk}) begin
      word = key[255 - 32*cmd.widx[2:0] -: 32];
    end else if (use_rcon) begin
      word = aes_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rcon, 24'h0} ^ back;
    end else if (nk == 4'd8 && cmd.wmod == 3'd4) begin
      word = aes_pkg::sub_word(prev) ^ back;
    end else begin
      word = prev ^ back;
    end
  end

  assign rk_we    = cmd.step && (cmd.widx[1:0] == 2'd3);
  assign rk_waddr = cmd.widx[WIDX_TOP:2];
  assign rk_wdata = {sh[2], sh[1], sh[0], word};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size <= aes_pkg::KS_128;
      key      <= '0;
      rcon     <= 8'h01;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          aes_pkg::CFG_KEY_SIZE: key_size <= cfg_data[1:0];
          aes_pkg::CFG_KEY_A:    key[255:192] <= cfg_data;
          aes_pkg::CFG_KEY_B:    key[191:128] <= cfg_data;
          aes_pkg::CFG_KEY_C:    key[127:64] <= cfg_data;
          aes_pkg::CFG_KEY_D:    key[63:0] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.init) begin
        rcon <= 8'h01;
      end else if (cmd.step && use_rcon) begin
        rcon <= aes_pkg::xt(rcon);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      sh[0] <= word;
      for (int i = 1; i < 8; i++) begin
        sh[i] <= sh[i-1];
      end
    end
  end

endmodule
`default_nettype wire

// File: src/aes_dp.sv
// ----------------------------------------------------------------------------
// aes_dp: cipher datapath
// Holds the mode and IV registers, the chaining value, the working block and
// the output register, and applies one AES round per command.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic [0:0]         in_func,
  input  logic [127:0]       in_block,
  input  logic [127:0]       rk,
  input  aes_pkg::dp_cmd_t   cmd,
  output aes_pkg::dp_stat_t  stat,
  output logic [127:0]       out_block
);

  logic [1:0]   mode;
  logic [63:0]  iv_high;
  logic [63:0]  iv_low;
  logic [127:0] cv;
  logic [127:0] blk;
  logic         fdec;
  logic         cdec;
  logic [127:0] st;
  logic [127:0] core_in;
  logic [127:0] res;
  logic [127:0] cv_next;

  assign stat.core_dec_in = in_func[0] && (mode == aes_pkg::MODE_ECB || mode == aes_pkg::MODE_CBC);

  always_comb begin
    case (mode)
      aes_pkg::MODE_ECB: core_in = in_block;
      aes_pkg::MODE_CBC: core_in = in_func[0] ? in_block : (in_block ^ cv);
      default:           core_in = cv;
    endcase
  end

  // Result and new chaining value once the core is done.
  always_comb begin
    case (mode)
      aes_pkg::MODE_ECB: begin
        res = st;
        cv_next = cv;
      end
      aes_pkg::MODE_CBC: begin
        res = fdec ? (st ^ cv) : st;
        cv_next = fdec ? blk : st;
      end
      aes_pkg::MODE_CFB: begin
        res = st ^ blk;
        cv_next = fdec ? blk : (st ^ blk);
      end
      default: begin
        res = st ^ blk;
        cv_next = st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= aes_pkg::MODE_ECB;
      iv_high <= '0;
      iv_low  <= '0;
      cv      <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          aes_pkg::CFG_MODE: mode <= cfg_data[1:0];
          aes_pkg::CFG_IV_HIGH: begin
            iv_high <= cfg_data;
            cv <= {cfg_data, iv_low};
          end
          aes_pkg::CFG_IV_LOW: begin
            iv_low <= cfg_data;
            cv <= {iv_high, cfg_data};
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        cv <= cv_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      blk  <= in_block;
      fdec <= in_func[0];
      cdec <= stat.core_dec_in;
      st   <= core_in;
    end else if (cmd.load) begin
      st <= st ^ rk;
    end else if (cmd.round) begin
      st <= cdec ? aes_pkg::dec_round(st, rk, cmd.last)
                 : aes_pkg::enc_round(st, rk, cmd.last);
    end
    if (cmd.finish) begin
      out_block <= res;
    end
  end

endmodule
`default_nettype wire

// File: src/aes_ctrl.sv
// ----------------------------------------------------------------------------
// aes_ctrl: sequencing state machine
// Runs key expansion after reset and after every key write, then steps each
// item through load, rounds and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      key_wr,
  input  logic [1:0]                key_size,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  input  aes_pkg::dp_stat_t         stat,
  output aes_pkg::kexp_cmd_t        kcmd,
  output aes_pkg::dp_cmd_t          dcmd,
  output logic [aes_pkg::RK_AW-1:0] raddr
);

  typedef enum logic [4:0] {
    S_EXPAND = 5'b00001,
    S_IDLE   = 5'b00010,
    S_LOAD   = 5'b00100,
    S_ROUND  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                      state, state_next;
  logic [aes_pkg::WIDX_W-1:0]  widx, widx_next;
  logic [2:0]                  wmod, wmod_next;
  logic [3:0]                  rnd, rnd_next;
  logic [aes_pkg::RK_AW-1:0]   row, row_next;
  logic                        m_tvalid_next;
  logic                        dec;
  logic [3:0]                  nr;
  logic [3:0]                  nk;
  logic [aes_pkg::WIDX_W-1:0]  last_word;
  logic                        accept;
  logic                        fin;

  assign nr = aes_pkg::nr_of(key_size);
  assign nk = aes_pkg::nk_of(key_size);
  assign last_word = aes_pkg::WIDX_W'({nr, 2'b11});
  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;
  assign fin = (state == S_DONE) && (!m_tvalid || m_tready);

  // The store has a registered read, so the row needed in a cycle is
  // addressed in the cycle before, from row_next.
  assign raddr = row_next;

  assign kcmd.init = key_wr;
  assign kcmd.step = (state == S_EXPAND);
  assign kcmd.widx = widx;
  assign kcmd.wmod = wmod;

  assign dcmd.capture = accept;
  assign dcmd.load    = (state == S_LOAD);
  assign dcmd.round   = (state == S_ROUND);
  assign dcmd.last    = (rnd == nr);
  assign dcmd.finish  = fin;

  always_comb begin
    state_next = state;
    widx_next = widx;
    wmod_next = wmod;
    rnd_next = rnd;
    row_next = row;
    m_tvalid_next = m_tvalid && !m_tready;
    unique case (state)
      S_EXPAND: begin
        widx_next = widx + 1'b1;
        wmod_next = ({1'b0, wmod} == nk - 4'd1) ? 3'd0 : wmod + 3'd1;
        if (widx == last_word) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          row_next = stat.core_dec_in ? nr : '0;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        rnd_next = 4'd1;
        row_next = dec ? row - 1'b1 : row + 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        rnd_next = rnd + 4'd1;
        row_next = dec ? row - 1'b1 : row + 1'b1;
        if (rnd == nr) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (fin) begin
          m_tvalid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (key_wr) begin
      state_next = S_EXPAND;
      widx_next = '0;
      wmod_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_EXPAND;
      widx     <= '0;
      wmod     <= '0;
      rnd      <= '0;
      row      <= '0;
      dec      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      widx     <= widx_next;
      wmod     <= wmod_next;
      rnd      <= rnd_next;
      row      <= row_next;
      m_tvalid <= m_tvalid_next;
      if (accept) begin
        dec <= stat.core_dec_in;
      end
    end
  end

  a_rnd_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (rnd <= nr && rnd != 4'd0))
    else $error("round counter out of range");

  a_expand_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXPAND) |-> (widx <= last_word))
    else $error("key expansion index past the store");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (accept && !key_wr) |=> (state == S_LOAD))
    else $error("accepted item did not start loading");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside of completion");

endmodule
`default_nettype wire

// File: src/aes_block_cipher_modes.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_modes: AES-128/192/256 with ECB, CBC, CFB and OFB chaining
// Iterative AES core, one round per cycle, with a round-key store filled by a
// word-per-cycle key expansion and a 128-bit chaining value.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  tdata: block_high, block_low; tuser: func
//  m_       out        m_tvalid/m_tready  tdata: result_high, result_low
//  cfg_     in         cfg_valid/cfg_ready cfg_index (register), cfg_data
//
// Each item passes through capture, the initial key add, the rounds of the
// shared round unit and the hand-off; no new item is accepted until the block
// is back in idle.
// The round-key store is read once per round through its single read port.
// After reset and after every key or key-size write, the key expansion runs
// through the whole key schedule and no item is accepted meanwhile.
// A finished result waits in the output register; the block holds its last
// item in completion while that register is still full.
//
`default_nettype none
module aes_block_cipher_modes (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // [63:0] block_high, [127:64] block_low
  input  logic [0:0]   s_tuser,   // [0] func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // [63:0] result_high, [127:64] result_low
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  aes_pkg::kexp_cmd_t          kcmd;
  aes_pkg::dp_cmd_t            dcmd;
  aes_pkg::dp_stat_t           dstat;
  logic                        cfg_wr;
  logic                        key_wr;
  logic [1:0]                  key_size;
  logic                        rk_we;
  logic [aes_pkg::RK_AW-1:0]   rk_waddr;
  logic [127:0]                rk_wdata;
  logic [aes_pkg::RK_AW-1:0]   rk_raddr;
  logic [127:0]                rk_rdata;
  logic [127:0]                out_block;

  // Configuration is always taken; a key register or key-size write restarts
  // the expansion.
  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign key_wr = cfg_wr && (cfg_index <= aes_pkg::CFG_KEY_D);

  // Internally the block is big-endian with byte 0 in bits [127:120].
  assign m_tdata = {out_block[63:0], out_block[127:64]};

  aes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .key_wr   (key_wr),
    .key_size (key_size),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (dstat),
    .kcmd     (kcmd),
    .dcmd     (dcmd),
    .raddr    (rk_raddr)
  );

  aes_kexp u_kexp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (kcmd),
    .key_size  (key_size),
    .rk_we     (rk_we),
    .rk_waddr  (rk_waddr),
    .rk_wdata  (rk_wdata)
  );

  aes_ram #(
    .WIDTH (128),
    .DEPTH (aes_pkg::RK_ROWS)
  ) u_rk_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  aes_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_func   (s_tuser),
    .in_block  ({s_tdata[63:0], s_tdata[127:64]}),
    .rk        (rk_rdata),
    .cmd       (dcmd),
    .stat      (dstat),
    .out_block (out_block)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for aes_block_cipher_modes
// Runs AES-128/192/256 blocks through every chaining mode and both
// directions. A local AES model predicts every output block, and the actual
// outputs are compared in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic        func;
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_item_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // [63:0] block_high, [127:64] block_low
  logic [0:0]   s_tuser = '0;   // [0] func
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // [63:0] result_high, [127:64] result_low
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  aes_block_cipher_modes i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the block's registers and state.
  logic [7:0]  sbox_lut [256];
  logic [7:0]  inv_lut [256];
  logic [31:0] key_sched [60];
  logic [1:0]  ks_reg;
  logic [1:0]  mode_reg;
  logic [63:0] key_reg [4];
  logic [63:0] iv_hi_reg, iv_lo_reg;
  logic [127:0] chain_val;

  blk_item_t    pending_blocks [$];
  logic [127:0] expected_blocks [$];   // {result_high, result_low}
  int           errors = 0;
  int           src_idle = 0;
  int           snk_stall = 0;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] b, int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  // The S-box is derived from its definition: GF(2^8) inverse, then the
  // affine map.
  task automatic build_sboxes();
    logic [7:0] v;
    for (int x = 0; x < 256; x++) begin
      v = 8'h00;
      for (int y = 1; y < 256; y++)
        if (x != 0 && gf_mul(x[7:0], y[7:0]) == 8'h01) v = y[7:0];
      sbox_lut[x] = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) inv_lut[sbox_lut[x]] = x[7:0];
  endtask

  function automatic int round_count();
    return (ks_reg == aes_pkg::KS_128) ? 10 : ((ks_reg == aes_pkg::KS_192) ? 12 : 14);
  endfunction

  function automatic logic [31:0] sub_bytes32(logic [31:0] w);
    return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
  endfunction

  // Key schedule; key size code three falls through to a 256-bit key.
  task automatic expand_schedule();
    int nk, total;
    logic [63:0] r;
    logic [31:0] t;
    logic [7:0]  rc;
    nk = (ks_reg == aes_pkg::KS_128) ? 4 : ((ks_reg == aes_pkg::KS_192) ? 6 : 8);
    total = 4 * (round_count() + 1);
    rc = 8'h01;
    for (int i = 0; i < 60; i++) key_sched[i] = '0;
    for (int i = 0; i < total; i++) begin
      if (i < nk) begin
        r = key_reg[(i >> 1) & 3];
        key_sched[i] = (i & 1) ? r[31:0] : r[63:32];
      end else begin
        t = key_sched[i-1];
        if (i % nk == 0) begin
          t = sub_bytes32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = gf_mul(rc, 8'h02);
        end else if (nk > 6 && i % nk == 4) begin
          t = sub_bytes32(t);
        end
        key_sched[i] = key_sched[i-nk] ^ t;
      end
    end
  endtask

  function automatic logic [127:0] round_key(int rnd);
    return {key_sched[4*rnd], key_sched[4*rnd+1], key_sched[4*rnd+2], key_sched[4*rnd+3]};
  endfunction

  // Byte k of the block is element k; element 0 sits in the top bits.
  function automatic logic [127:0] aes_block(logic dec, logic [127:0] blk);
    logic [0:15][7:0] s;
    logic [0:15][7:0] t;
    logic [7:0] a0, a1, a2, a3;
    int nr;
    nr = round_count();
    s = blk;
    if (!dec) begin
      s = s ^ round_key(0);
      for (int rnd = 1; rnd <= nr; rnd++) begin
        for (int k = 0; k < 16; k++) s[k] = sbox_lut[s[k]];
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[4*c+r] = s[4*((c+r)%4)+r];
        if (rnd != nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            s[4*c]   = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
            s[4*c+1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
            s[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
            s[4*c+3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
          end
        end else begin
          s = t;
        end
        s = s ^ round_key(rnd);
      end
    end else begin
      s = s ^ round_key(nr);
      for (int rnd = nr; rnd >= 1; rnd--) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[4*((c+r)%4)+r] = s[4*c+r];
        for (int k = 0; k < 16; k++) s[k] = inv_lut[t[k]];
        s = s ^ round_key(rnd - 1);
        if (rnd != 1) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            s[4*c]   = gf_mul(a0, 8'h0e) ^ gf_mul(a1, 8'h0b) ^ gf_mul(a2, 8'h0d)
                       ^ gf_mul(a3, 8'h09);
            s[4*c+1] = gf_mul(a0, 8'h09) ^ gf_mul(a1, 8'h0e) ^ gf_mul(a2, 8'h0b)
                       ^ gf_mul(a3, 8'h0d);
            s[4*c+2] = gf_mul(a0, 8'h0d) ^ gf_mul(a1, 8'h09) ^ gf_mul(a2, 8'h0e)
                       ^ gf_mul(a3, 8'h0b);
            s[4*c+3] = gf_mul(a0, 8'h0b) ^ gf_mul(a1, 8'h0d) ^ gf_mul(a2, 8'h09)
                       ^ gf_mul(a3, 8'h0e);
          end
        end
      end
    end
    return s;
  endfunction

  // Works out the output block of one accepted item and moves the chain.
  task automatic predict_block(logic dec, logic [127:0] din);
    logic [127:0] dout, k;
    case (mode_reg)
      aes_pkg::MODE_ECB: dout = aes_block(dec, din);
      aes_pkg::MODE_CBC: begin
        if (!dec) begin
          dout = aes_block(1'b0, din ^ chain_val);
          chain_val = dout;
        end else begin
          dout = aes_block(1'b1, din) ^ chain_val;
          chain_val = din;
        end
      end
      aes_pkg::MODE_CFB: begin
        dout = aes_block(1'b0, chain_val) ^ din;
        chain_val = dec ? din : dout;
      end
      default: begin
        k = aes_block(1'b0, chain_val);
        chain_val = k;
        dout = k ^ din;
      end
    endcase
    expected_blocks.push_back(dout);
  endtask

  task automatic apply_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      aes_pkg::CFG_KEY_SIZE: begin ks_reg = val[1:0]; expand_schedule(); end
      aes_pkg::CFG_KEY_A:    begin key_reg[0] = val; expand_schedule(); end
      aes_pkg::CFG_KEY_B:    begin key_reg[1] = val; expand_schedule(); end
      aes_pkg::CFG_KEY_C:    begin key_reg[2] = val; expand_schedule(); end
      aes_pkg::CFG_KEY_D:    begin key_reg[3] = val; expand_schedule(); end
      aes_pkg::CFG_MODE:     mode_reg = val[1:0];
      aes_pkg::CFG_IV_HIGH:  begin iv_hi_reg = val; chain_val = {iv_hi_reg, iv_lo_reg}; end
      default:               begin iv_lo_reg = val; chain_val = {iv_hi_reg, iv_lo_reg}; end
    endcase
  endtask

  // Driver: feeds pending items to the slave side. The accepted item is
  // predicted at the edge that takes it, with the values it carried.
  always @(posedge clk) begin
    blk_item_t nxt;
    logic      load;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) predict_block(s_tuser[0], {s_tdata[63:0], s_tdata[127:64]});
      load = pending_blocks.size() != 0 && $urandom_range(99) >= src_idle;
      if (load) begin
        nxt = pending_blocks.pop_front();
        s_tdata  <= {nxt.lo, nxt.hi};
        s_tuser  <= nxt.func;
      end
      s_tvalid <= load;
    end
  end

  // Monitor: random back-pressure, in-order comparison against predictions.
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected output block %h_%h", $time,
                   m_tdata[63:0], m_tdata[127:64]);
          errors++;
        end else begin
          want = expected_blocks.pop_front();
          if (m_tdata[63:0] !== want[127:64]) begin
            $display("%0t: result_high expected %h actual %h", $time,
                     want[127:64], m_tdata[63:0]);
            errors++;
          end
          if (m_tdata[127:64] !== want[63:0]) begin
            $display("%0t: result_low expected %h actual %h", $time,
                     want[63:0], m_tdata[127:64]);
            errors++;
          end
        end
      end
      m_tready <= $urandom_range(99) >= snk_stall;
    end
  end

  // One register write; returns in the cycle after the write, with valid low.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every item is taken and every output block has come, then
  // lets the core drain.
  task automatic wait_idle();
    while (pending_blocks.size() != 0 || s_tvalid || expected_blocks.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_block(logic func, logic [63:0] hi, logic [63:0] lo);
    blk_item_t it;
    it.func = func; it.hi = hi; it.lo = lo;
    pending_blocks.push_back(it);
  endtask

  initial begin
    logic [63:0] fill;
    int          pick;
    build_sboxes();
    ks_reg = aes_pkg::KS_128; mode_reg = aes_pkg::MODE_ECB;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    iv_hi_reg = '0; iv_lo_reg = '0; chain_val = '0;
    expand_schedule();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings (zero 128-bit key, ECB), extreme blocks.
    queue_block(1'b0, '0, '0);
    queue_block(1'b0, '1, '1);
    queue_block(1'b1, '0, '0);
    queue_block(1'b1, '1, '1);
    wait_idle();

    // Directed: a 128-bit key with junk in the unused key registers.
    write_reg(aes_pkg::CFG_KEY_A, 64'h0001020304050607);
    write_reg(aes_pkg::CFG_KEY_B, 64'h08090a0b0c0d0e0f);
    write_reg(aes_pkg::CFG_KEY_C, '1);
    write_reg(aes_pkg::CFG_KEY_D, 64'h5a5a5a5a5a5a5a5a);
    queue_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    wait_idle();

    // Directed: key size code three acts as a 256-bit key, in every mode.
    write_reg(aes_pkg::CFG_KEY_SIZE, 64'd3);
    for (int m = 0; m < 4; m++) begin
      write_reg(aes_pkg::CFG_MODE, 64'(m));
      write_reg(aes_pkg::CFG_IV_HIGH, 64'h0011223344556677);
      write_reg(aes_pkg::CFG_IV_LOW, 64'hffeeddccbbaa9988);
      queue_block(1'b0, rand64(), rand64());
      queue_block(1'b1, rand64(), rand64());
      queue_block(1'b0, '1, '0);
      queue_block(1'b1, '0, '1);
      wait_idle();
    end

    // Random phases over all key sizes and modes; four idling profiles.
    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 84; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 84; end
        default: begin src_idle = 20; snk_stall = 20; end
      endcase
      write_reg(aes_pkg::CFG_MODE, 64'((p / 4) % 4));
      write_reg(aes_pkg::CFG_KEY_SIZE, 64'(p % 4));
      for (int r = 0; r < 4; r++) begin
        fill = (p == 0) ? 64'h0 : ((p == 15) ? '1 : rand64());
        write_reg(3'(aes_pkg::CFG_KEY_A + r), fill);
      end
      fill = (p == 0) ? 64'h0 : ((p == 15) ? '1 : rand64());
      write_reg(aes_pkg::CFG_IV_HIGH, fill);
      fill = (p == 0) ? 64'h0 : ((p == 15) ? '1 : rand64());
      write_reg(aes_pkg::CFG_IV_LOW, fill);
      for (int n = 0; n < 34; n++) begin
        pick = $urandom_range(15);
        if (pick == 0)      queue_block(1'($urandom_range(1)), '0, '0);
        else if (pick == 1) queue_block(1'($urandom_range(1)), '1, '1);
        else                queue_block(1'($urandom_range(1)), rand64(), rand64());
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
